// ===== rtl/min_max_heap_priority_queue_macros.svh =====
// assertion macros for the min-max heap priority queue
// used by the top level only, no other dependencies
`ifndef MIN_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MIN_MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

// property that holds at every edge outside reset
`define MMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the cycle after the condition
`define MMH_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/mmh_pkg.sv =====
// shared types and constants for the min-max heap priority queue
// no dependencies
`default_nettype none

package mmh_pkg;

  localparam int HeapDepth  = 1024;
  localparam int ValueWidth = 32;
  localparam int AddrWidth  = $clog2(HeapDepth + 1);
  localparam int CountWidth = 11;

  localparam logic [2:0] ACT_INSERT   = 3'd0;
  localparam logic [2:0] ACT_FIND_MIN = 3'd1;
  localparam logic [2:0] ACT_FIND_MAX = 3'd2;
  localparam logic [2:0] ACT_DEL_MIN  = 3'd3;
  localparam logic [2:0] ACT_DEL_MAX  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // compare unit operations
  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_GT = 2'd1;
  localparam logic [1:0] CMP_GE = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
    logic [10:0]        count_after;
  } rsp_t;

  typedef struct packed {
    logic                  we;
    logic [AddrWidth-1:0]  waddr;
    logic [ValueWidth-1:0] wdata;
    logic [AddrWidth-1:0]  raddr;
  } mem_req_t;

  // true when the 1-based position lies on an even (minimum) level
  function automatic logic min_level(input logic [AddrWidth-1:0] i);
    logic [$clog2(AddrWidth+1)-1:0] msb;
    msb = '0;
    for (int k = 0; k < AddrWidth; k++) begin
      if (i[k]) msb = k[$clog2(AddrWidth+1)-1:0];
    end
    return ~msb[0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/min_max_heap_priority_queue.sv =====
// Double-ended priority queue held as a min-max heap in one single-port memory
// of 1025 words (1-based). How long one request takes is set by the heap
// walk: every memory read is an address and then registered data, reads and
// writes all go through the one memory port, and every decision goes
// through one shared compare unit. An insert climbs one grandparent level per
// step; a delete trickles down one grandchild level per step.
// A new request is taken only when the previous answer has left the output
// register. The capacity register is written on its own channel, ready whenever
// the block is idle.
// The store needs no clearing pass: only entries within the current count are used.
// depends on mmh_pkg, mmh_ram, mmh_cmp and the assertion macro header
`default_nettype none

`include "min_max_heap_priority_queue_macros.svh"

module min_max_heap_priority_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mmh_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mmh_pkg::rsp_t      out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [10:0]   cfg_data
);

  localparam int AW = mmh_pkg::AddrWidth;
  localparam int VW = mmh_pkg::ValueWidth;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RD     = 5'd1;   // read address issued, wait for data
  localparam logic [4:0] S_DISP   = 5'd2;   // dispatch after request
  localparam logic [4:0] S_INS0   = 5'd3;   // compare new with parent
  localparam logic [4:0] S_BUB    = 5'd4;   // bubble: compare with grandparent
  localparam logic [4:0] S_MAXP   = 5'd5;   // compare pos 2 and 3
  localparam logic [4:0] S_FIND   = 5'd6;
  localparam logic [4:0] S_DEL0   = 5'd7;   // have hole value, read last
  localparam logic [4:0] S_DEL1   = 5'd8;   // write last into hole
  localparam logic [4:0] S_TCAND  = 5'd9;   // candidate scan
  localparam logic [4:0] S_TDEC   = 5'd10;  // compare best with node
  localparam logic [4:0] S_TPAR   = 5'd11;  // compare with parent of best
  localparam logic [4:0] S_DONE   = 5'd12;
  localparam logic [4:0] S_OUT    = 5'd13;
  localparam logic [4:0] S_W2     = 5'd14;  // second write of a swap

  logic [4:0]    state, ret;
  logic [2:0]    act;
  logic [10:0]   capacity, count;
  logic [AW-1:0] pos, par, best, nodei, waddr2;
  logic [VW-1:0] val, cur, bestv, nodev, wdata2;
  logic [2:0]    cand;
  logic          bmax, lo;
  logic [31:0]   res;
  logic [1:0]    status;

  mmh_pkg::mem_req_t mreq;
  logic [VW-1:0]     rdata;
  logic [1:0]        cop;
  logic [VW-1:0]     ca, cb;
  logic              hit;

  mmh_ram u_ram (.clk(clk), .req(mreq), .rdata(rdata));
  mmh_cmp u_cmp (.op(cop), .a(ca), .b(cb), .hit(hit));

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = '{result_value: res, status: status, count_after: count};

  // candidate position of the trickle scan: children then grandchildren
  logic [AW+1:0] cpos_w;
  logic [AW-1:0] cpos;
  logic          cvalid;
  always_comb begin
    if (cand < 3'd2) cpos_w = {1'b0, nodei, 1'b0} + (AW+2)'(cand);
    else             cpos_w = {nodei, 2'b00} + (AW+2)'(cand - 3'd2);
    cvalid = (cpos_w <= (AW+2)'(count)) && (cand < 3'd6);
    cpos   = cpos_w[AW-1:0];
  end

  // shared compare operand selection
  always_comb begin
    cop = mmh_pkg::CMP_LT; ca = cur; cb = rdata;
    unique case (state)
      S_INS0:  begin cop = lo ? mmh_pkg::CMP_GT : mmh_pkg::CMP_LT; ca = val; end
      S_BUB:   begin cop = bmax ? mmh_pkg::CMP_GT : mmh_pkg::CMP_LT; ca = val; end
      S_MAXP:  begin cop = mmh_pkg::CMP_GE; ca = cur; end
      S_TCAND: begin cop = lo ? mmh_pkg::CMP_LT : mmh_pkg::CMP_GT; ca = rdata; cb = bestv; end
      S_TDEC:  begin cop = lo ? mmh_pkg::CMP_LT : mmh_pkg::CMP_GT; ca = bestv; cb = nodev; end
      S_TPAR:  begin cop = lo ? mmh_pkg::CMP_GT : mmh_pkg::CMP_LT; ca = nodev; cb = rdata; end
      default: ;
    endcase
  end

  logic [10:0] limit;
  assign limit = (capacity < 11'(mmh_pkg::HeapDepth)) ? capacity : 11'(mmh_pkg::HeapDepth);

  always_comb begin
    mreq = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
    unique case (state)
      S_IDLE:  mreq.raddr = AW'(2);
      S_DISP:  mreq.raddr = (act == mmh_pkg::ACT_INSERT) ? (AW'(count) >> 1) : AW'(3);
      S_DEL0:  mreq.raddr = AW'(count);
      S_TCAND: mreq.raddr = cpos;
      default: mreq.raddr = par;
    endcase
    if (state == S_W2) begin
      mreq.we = 1'b1; mreq.waddr = waddr2; mreq.wdata = wdata2;
    end
  end

  // write port shared through a small pending-write pair
  logic          wpend;
  logic [AW-1:0] wa;
  logic [VW-1:0] wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= 11'd1024;
      count    <= '0;
      wpend    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) capacity <= cfg_data;
          if (in_valid) begin
            act <= in_data.action; val <= in_data.value;
            res <= '0; status <= mmh_pkg::ST_OK;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          // rdata holds entry 2 here (read issued in idle); decode action
          cur <= rdata;
          if (act == mmh_pkg::ACT_INSERT) begin
            if (count >= limit) begin
              status <= mmh_pkg::ST_FULL; state <= S_OUT;
            end else begin
              pos <= AW'(count + 11'd1); count <= count + 11'd1;
              lo  <= mmh_pkg::min_level(AW'(count + 11'd1));
              par <= AW'(count + 11'd1) >> 1;
              if (count == 11'd0) begin
                waddr2 <= AW'(1); wdata2 <= val; ret <= S_OUT; state <= S_W2;
              end else begin
                state <= S_RD; ret <= S_INS0;
              end
            end
          end else if (act >= mmh_pkg::ACT_FIND_MIN && act <= mmh_pkg::ACT_DEL_MAX) begin
            if (count == 11'd0) begin
              status <= mmh_pkg::ST_EMPTY; state <= S_OUT;
            end else begin
              state <= S_RD; ret <= S_MAXP; par <= AW'(3);
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_RD: state <= ret;
        S_MAXP: begin
          // rdata = entry 3 (issued in S_RD); cur = entry 2
          // choose target position, then read it
          if (act == mmh_pkg::ACT_FIND_MIN || act == mmh_pkg::ACT_DEL_MIN
              || count == 11'd1) best <= AW'(1);
          else if (count == 11'd2 || hit) best <= AW'(2);
          else best <= AW'(3);
          if (act == mmh_pkg::ACT_FIND_MIN || act == mmh_pkg::ACT_DEL_MIN
              || count == 11'd1) par <= AW'(1);
          else if (count == 11'd2 || hit) par <= AW'(2);
          else par <= AW'(3);
          state <= S_RD; ret <= S_FIND;
        end
        S_FIND: begin
          res <= rdata;
          if (act == mmh_pkg::ACT_FIND_MIN || act == mmh_pkg::ACT_FIND_MAX) begin
            state <= S_OUT;
          end else begin
            nodei <= best;
            state <= S_DEL0;
          end
        end
        S_DEL0: state <= S_DEL1;   // last entry read in flight
        S_DEL1: begin
          nodev <= rdata; count <= count - 11'd1;
          waddr2 <= nodei; wdata2 <= rdata;
          lo <= mmh_pkg::min_level(nodei);
          if (nodei <= AW'(count - 11'd1)) begin
            cand <= 3'd0; ret <= S_TCAND;
          end else ret <= S_OUT;
          state <= S_W2;
        end
        S_TCAND: begin
          // rdata: value of previous candidate address (issued last cycle)
          if (cand != 3'd0 && wpend) begin
            if (cand == 3'd1 || hit) begin bestv <= rdata; best <= wa; end
          end
          wpend <= cvalid;
          wa    <= cpos;
          if (cvalid) cand <= cand + 3'd1;
          else if (cand == 3'd0) state <= S_OUT;
          else if (!wpend) state <= S_TDEC;
          else state <= S_TCAND;
        end
        S_TDEC: begin
          if (!hit) begin
            wpend <= 1'b0;
            state <= S_OUT;
          end else begin
            // swap best into node, node value into best
            waddr2 <= nodei; wdata2 <= bestv;
            wa <= best; wd <= nodev;
            wpend <= 1'b1;
            ret <= ({2'b00, best} < {nodei, 2'b00}) ? S_OUT : S_TPAR;
            par <= best >> 1;
            state <= S_W2;
          end
        end
        S_TPAR: begin
          // rdata: parent of best; nodev now sits at best
          nodei <= best;
          cand  <= 3'd0;
          if (hit) begin
            waddr2 <= best >> 1; wdata2 <= nodev;
            wa <= best; wd <= rdata; wpend <= 1'b1;
            nodev <= rdata;
          end
          ret <= S_TCAND;
          state <= S_W2;
        end
        S_INS0: begin
          // rdata holds the parent
          if (hit) begin
            // swap new with parent, then bubble from parent on the other level
            waddr2 <= par; wdata2 <= val;
            wa <= pos; wd <= rdata; wpend <= 1'b1;
            pos <= par; bmax <= lo;
          end else begin
            waddr2 <= pos; wdata2 <= val; bmax <= ~lo;
          end
          ret <= S_BUB; state <= S_W2;
          par <= (hit ? par : pos) >> 2;
        end
        S_BUB: begin
          if (pos >= AW'(4) && hit) begin
            waddr2 <= pos >> 2; wdata2 <= val;
            wa <= pos; wd <= rdata; wpend <= 1'b1;
            pos <= pos >> 2; par <= pos >> 4;
            ret <= S_BUB; state <= S_W2;
          end else state <= S_OUT;
        end
        S_W2: begin
          if (wpend) begin
            waddr2 <= wa; wdata2 <= wd; wpend <= 1'b0;
          end else begin
            if (ret == S_TCAND) state <= S_TCAND;
            else if (ret == S_BUB && pos < AW'(4)) state <= S_OUT;
            else state <= (ret == S_OUT) ? S_OUT : S_RD;
          end
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `MMH_ASSERT(a_count_range, count <= 11'(mmh_pkg::HeapDepth), "element count beyond store depth")
  `MMH_ASSERT(a_ready_excl, !(in_ready && out_valid), "input ready while a result waits")
  `MMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

endmodule

`default_nettype wire

// ===== rtl/mmh_ram.sv =====
// single-port heap store, one write and one registered read per cycle
// depends on mmh_pkg
`default_nettype none

module mmh_ram (
  input  wire logic                          clk,
  input  wire mmh_pkg::mem_req_t             req,
  output logic [mmh_pkg::ValueWidth-1:0]     rdata
);

  logic [mmh_pkg::ValueWidth-1:0] mem [0:mmh_pkg::HeapDepth];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mmh_cmp.sv =====
// shared signed compare unit used by every heap walk
// depends on mmh_pkg
`default_nettype none

module mmh_cmp (
  input  wire logic [1:0]                    op,
  input  wire logic [mmh_pkg::ValueWidth-1:0] a,
  input  wire logic [mmh_pkg::ValueWidth-1:0] b,
  output logic                               hit
);

  always_comb begin
    case (op)
      mmh_pkg::CMP_LT: hit = $signed(a) <  $signed(b);
      mmh_pkg::CMP_GT: hit = $signed(a) >  $signed(b);
      mmh_pkg::CMP_GE: hit = $signed(a) >= $signed(b);
      default:         hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb_min_max_heap_priority_queue.sv =====
// testbench for the min-max heap priority queue: random and directed requests
// checked against an in-bench heap predictor; depends on mmh_pkg and the block
module tb_min_max_heap_priority_queue;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  mmh_pkg::req_t in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  mmh_pkg::rsp_t out_data;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  [10:0] cfg_data = '0;

  min_max_heap_priority_queue uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state: keys are values with the sign bit flipped so that
  // unsigned compares give signed order
  logic [31:0] heap_keys [1:1024];
  int unsigned heap_count;
  int unsigned cap_limit;
  mmh_pkg::rsp_t pending_rsp [$];
  int          fail_count;
  int          rsp_seen;
  bit          idle_out;    // receiver idling enabled
  bit          idle_in;     // sender idling enabled
  int          hold_cycles; // long receiver hold-off, counted by the receiver
  int          stall_left;  // cycles left in a receiver idle burst

  function automatic bit on_min_level(int unsigned i);
    int d;
    d = 0;
    while (i > 1) begin
      i = i >> 1;
      d++;
    end
    return (d % 2) == 0;
  endfunction

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic [31:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void climb(int unsigned i, bit toward_min);
    while (i >= 4 && (toward_min ? heap_keys[i] < heap_keys[i >> 2]
                                 : heap_keys[i] > heap_keys[i >> 2])) begin
      swap_keys(i, i >> 2);
      i = i >> 2;
    end
  endfunction

  // published trickle-down over children and grandchildren
  function automatic void sink(int unsigned i);
    bit          lo;
    int unsigned m;
    int unsigned cand [6];
    forever begin
      lo = on_min_level(i);
      if (2 * i > heap_count) return;
      cand = '{2*i, 2*i+1, 4*i, 4*i+1, 4*i+2, 4*i+3};
      m = 2 * i;
      for (int k = 1; k < 6; k++) begin
        if (cand[k] > heap_count) break;
        if (lo ? heap_keys[cand[k]] < heap_keys[m] : heap_keys[cand[k]] > heap_keys[m])
          m = cand[k];
      end
      if (lo ? !(heap_keys[m] < heap_keys[i]) : !(heap_keys[m] > heap_keys[i])) return;
      swap_keys(m, i);
      if (m < 4 * i) return;
      if (lo ? heap_keys[m] > heap_keys[m >> 1] : heap_keys[m] < heap_keys[m >> 1])
        swap_keys(m, m >> 1);
      i = m;
    end
  endfunction

  function automatic int unsigned top_pos();
    if (heap_count == 1) return 1;
    if (heap_count == 2 || heap_keys[2] >= heap_keys[3]) return 2;
    return 3;
  endfunction

  // works out the answer to one request and updates the predicted heap
  function automatic mmh_pkg::rsp_t heap_apply(mmh_pkg::req_t r);
    mmh_pkg::rsp_t a;
    logic [31:0] k;
    int unsigned n, p, m;
    k = 32'h8000_0000;
    a.status = mmh_pkg::ST_OK;
    n = heap_count;
    if (r.action == mmh_pkg::ACT_INSERT) begin
      if (n >= cap_limit) a.status = mmh_pkg::ST_FULL;
      else begin
        n++;
        heap_count = n;
        heap_keys[n] = r.value ^ 32'h8000_0000;
        if (n > 1) begin
          p = n >> 1;
          if (on_min_level(n)) begin
            if (heap_keys[n] > heap_keys[p]) begin
              swap_keys(n, p);
              climb(p, 1'b0);
            end else climb(n, 1'b1);
          end else begin
            if (heap_keys[n] < heap_keys[p]) begin
              swap_keys(n, p);
              climb(p, 1'b1);
            end else climb(n, 1'b0);
          end
        end
      end
    end else if (r.action inside {mmh_pkg::ACT_FIND_MIN, mmh_pkg::ACT_FIND_MAX,
                                  mmh_pkg::ACT_DEL_MIN, mmh_pkg::ACT_DEL_MAX}) begin
      if (n == 0) a.status = mmh_pkg::ST_EMPTY;
      else if (r.action == mmh_pkg::ACT_FIND_MIN) k = heap_keys[1];
      else if (r.action == mmh_pkg::ACT_FIND_MAX) k = heap_keys[top_pos()];
      else begin
        m = (r.action == mmh_pkg::ACT_DEL_MIN) ? 1 : top_pos();
        k = heap_keys[m];
        heap_keys[m] = heap_keys[n];
        n--;
        heap_count = n;
        if (m <= n) sink(m);
      end
    end
    a.result_value = k ^ 32'h8000_0000;
    a.count_after = heap_count[10:0];
    return a;
  endfunction

  // sends one request beat and records its expected answer
  task automatic send_req(logic [2:0] act, logic [31:0] val);
    mmh_pkg::req_t r;
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    r.action = act;
    r.value = val;
    in_data <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_rsp.push_back(heap_apply(r));
  endtask

  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_capacity(logic [10:0] c);
    drain_answers();
    cfg_data <= c;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_limit = (c < 1024) ? c : 1024;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 3;
      3: return $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  // result checker: each answer beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        rsp_seen++;
        if (pending_rsp.size() == 0) begin
          $error("answer with none expected: %p", out_data);
          fail_count++;
        end else begin
          mmh_pkg::rsp_t e;
          e = pending_rsp.pop_front();
          if (out_data.result_value !== e.result_value) begin
            $error("result_value exp %0d got %0d", e.result_value, out_data.result_value);
            fail_count++;
          end
          if (out_data.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_data.status);
            fail_count++;
          end
          if (out_data.count_after !== e.count_after) begin
            $error("count_after exp %0d got %0d", e.count_after, out_data.count_after);
            fail_count++;
          end
        end
      end
      // receiver: long hold-off when asked, else random stall bursts
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idle_out && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  // directed corners: empty, unused codes, extremes, every action
  task automatic test_directed();
    send_req(mmh_pkg::ACT_FIND_MIN, 0);
    send_req(mmh_pkg::ACT_FIND_MAX, 0);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
    send_req(mmh_pkg::ACT_DEL_MAX, 0);
    send_req(3'd5, 32'hffff_ffff);
    send_req(3'd6, 0);
    send_req(3'd7, 32'h5555_aaaa);
    send_req(mmh_pkg::ACT_INSERT, 32'h8000_0000);
    send_req(mmh_pkg::ACT_INSERT, 32'h7fff_ffff);
    send_req(mmh_pkg::ACT_INSERT, 32'h0000_0000);
    send_req(mmh_pkg::ACT_INSERT, 32'h7fff_ffff); // tie for maximum
    send_req(mmh_pkg::ACT_INSERT, 32'hffff_ffff);
    send_req(mmh_pkg::ACT_FIND_MIN, 0);
    send_req(mmh_pkg::ACT_FIND_MAX, 0);
    send_req(mmh_pkg::ACT_DEL_MAX, 0);
    send_req(mmh_pkg::ACT_DEL_MAX, 0);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
  endtask

  // small capacities: full refusals, then capacity dropped below the count
  task automatic test_capacity();
    set_capacity(11'd0);
    send_req(mmh_pkg::ACT_INSERT, 32'd7);
    set_capacity(11'd3);
    repeat (5) send_req(mmh_pkg::ACT_INSERT, pick_value());
    set_capacity(11'd1);
    send_req(mmh_pkg::ACT_INSERT, 32'd1);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
    send_req(mmh_pkg::ACT_DEL_MAX, 0);
    send_req(mmh_pkg::ACT_INSERT, 32'd2);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
    send_req(mmh_pkg::ACT_DEL_MIN, 0);
    set_capacity(11'd2047);
  endtask

  // random mix weighted by phase so the heap grows deep and then drains
  task automatic test_random(int items, int grow_pct);
    int a;
    for (int i = 0; i < items; i++) begin
      a = $urandom_range(0, 99);
      if (a < grow_pct) send_req(mmh_pkg::ACT_INSERT, pick_value());
      else if (a < grow_pct + 8) send_req(mmh_pkg::ACT_FIND_MIN, $urandom);
      else if (a < grow_pct + 16) send_req(mmh_pkg::ACT_FIND_MAX, $urandom);
      else if (a < grow_pct + 17) send_req(3'($urandom_range(5, 7)), $urandom);
      else if (a % 2 == 0) send_req(mmh_pkg::ACT_DEL_MIN, $urandom);
      else send_req(mmh_pkg::ACT_DEL_MAX, $urandom);
    end
  endtask

  // receiver holds off while requests keep coming, then a full pause
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 12; i++) send_req(mmh_pkg::ACT_INSERT, pick_value());
    drain_answers();
    for (int i = 0; i < 12; i++) send_req(mmh_pkg::ACT_DEL_MAX, 0);
  endtask

  initial begin
    heap_count = 0;
    cap_limit = 1024;
    fail_count = 0;
    rsp_seen = 0;
    idle_out = 1'b1;
    idle_in = 1'b1;
    hold_cycles = 0;
    stall_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_capacity();
    test_backpressure();
    test_random(250, 70);
    test_random(150, 40);
    set_capacity(11'd1024);
    test_random(150, 50);
    set_capacity(11'd40);
    test_random(100, 60);
    set_capacity(11'd1024);
    idle_out = 1'b0;
    idle_in = 1'b0;
    test_random(150, 35);
    drain_answers();
    $display("covered %0d answers: empty, full, capacity 0/1/3/40/1024/2047, ties, stalls",
             rsp_seen);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #12000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
